FILE: rtl/lzss_ring_decompressor_assert.svh
// ----------------------------------------------------------------------------
// lzss_ring_decompressor_assert.svh
// Assertion macros shared by the checker of the LZSS decompressor.
// ----------------------------------------------------------------------------
`ifndef LZSS_RING_DECOMPRESSOR_ASSERT_SVH
`define LZSS_RING_DECOMPRESSOR_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define LZSS_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LZSS_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lzss_pkg.sv
// ----------------------------------------------------------------------------
// lzss_pkg
// Types and constants shared by the LZSS ring decompressor modules.
// ----------------------------------------------------------------------------
package lzss_pkg;

    localparam int unsigned WINDOW_SIZE  = 4096;
    localparam int unsigned HEADER_BYTES = 16;
    localparam int unsigned RING_AW      = $clog2(WINDOW_SIZE);
    localparam logic [RING_AW-1:0] RING_START = RING_AW'(WINDOW_SIZE - 18);
    localparam logic [RING_AW-1:0] RING_LAST  = RING_AW'(WINDOW_SIZE - 1);
    localparam logic [RING_AW-1:0] RING_STEP  = RING_AW'(1);

    // Container magic, first byte first.
    localparam logic [7:0] MAGIC [4] = '{8'h53, 8'h53, 8'h5A, 8'h4C};

    // Configuration register indexes.
    localparam logic REG_SOURCE_SIZE = 1'b0;
    localparam logic REG_MAX_OUTPUT  = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC  = 3'd1;
    localparam logic [2:0] ST_BAD_SIZES  = 3'd2;
    localparam logic [2:0] ST_EXHAUSTED  = 3'd3;
    localparam logic [2:0] ST_OVERRUN    = 3'd4;

    // Command kinds passed from the front end to the back end.
    localparam logic [1:0] CMD_LIT   = 2'd0;
    localparam logic [1:0] CMD_MATCH = 2'd1;
    localparam logic [1:0] CMD_ERR   = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         data;    // literal byte
        logic [RING_AW-1:0] pos;     // match source position
        logic [4:0]         len;     // match length, 3 to 18
        logic               done;    // the command ends the stream
        logic [2:0]         status;  // error code for CMD_ERR
    } cmd_t;

endpackage

FILE: rtl/lzss_ring_decompressor.sv
// ----------------------------------------------------------------------------
// lzss_ring_decompressor
// Streaming LZSS decoder with a 4 KiB history ring, header checking and
// error reporting.
// ----------------------------------------------------------------------------
//  Channel | Ports                                     | Role
//  s_      | s_valid s_ready s_in_byte                 | container bytes in
//  m_      | m_valid m_ready m_out_byte m_run_last     | decoded bytes out
//          | m_stream_done m_status                    |
//  cfg_    | cfg_we cfg_index cfg_wdata                | register writes
//
//  After reset all 4096 ring entries are cleared; s_ready stays low meanwhile.
//  A match copies 3 to 18 bytes through the single ring write port.
//  A two-entry command queue lets the front end keep taking beats while the
//  back end copies; either side stalls on its own.
// ----------------------------------------------------------------------------
module lzss_ring_decompressor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_run_last,
    output logic        m_stream_done,
    output logic [2:0]  m_status,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);
    import lzss_pkg::*;

    logic [31:0] source_size_reg;
    logic [31:0] max_output_reg;
    logic        in_beat, push, pop, full, empty, busy;
    cmd_t        push_cmd, pop_cmd;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_size_reg <= 32'd16;
            max_output_reg  <= 32'hFFFF_FFFF;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SOURCE_SIZE: source_size_reg <= cfg_wdata;
                REG_MAX_OUTPUT:  max_output_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_ready = !full && !busy;
    assign in_beat = s_valid && s_ready;

    lzss_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_beat         (in_beat),
        .in_byte         (s_in_byte),
        .source_size     (source_size_reg),
        .max_output_size (max_output_reg),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    lzss_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    lzss_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_empty     (empty),
        .cmd           (pop_cmd),
        .pop           (pop),
        .busy          (busy),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last),
        .m_stream_done (m_stream_done),
        .m_status      (m_status)
    );

endmodule

FILE: rtl/lzss_cmd_fifo.sv
// ----------------------------------------------------------------------------
// lzss_cmd_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lzss_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lzss_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output lzss_pkg::cmd_t pop_cmd,
    output logic           empty
);
    import lzss_pkg::*;

    cmd_t       mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;

    // Pointer and fill count update.
    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) begin
            wptr_next = ~wptr_reg;
        end
        if (pop) begin
            rptr_next = ~rptr_reg;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_cmd;
        end
    end

    assign pop_cmd = mem_reg[rptr_reg];
    assign full    = cnt_reg[1];
    assign empty   = (cnt_reg == 2'd0);

endmodule

FILE: rtl/lzss_front.sv
// ----------------------------------------------------------------------------
// lzss_front
// Parses the header and the flag stream and issues literal, match and
// error commands.
// ----------------------------------------------------------------------------
module lzss_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_beat,
    input  logic [7:0]     in_byte,
    input  logic [31:0]    source_size,
    input  logic [31:0]    max_output_size,
    output logic           push,
    output lzss_pkg::cmd_t push_cmd
);
    import lzss_pkg::*;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_MATCH2  = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  hdr_reg, hdr_next;
    logic [31:0] psize_reg, psize_next;
    logic [31:0] osize_reg, osize_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] pleft_reg, pleft_next;
    logic [8:0]  flag_reg, flag_next;
    logic [7:0]  low_reg, low_next;

    logic [31:0] osize_full;
    logic [32:0] psize_sum;
    logic        last_byte;
    logic [4:0]  mlen;
    logic [31:0] mlen_w;

    assign osize_full = {in_byte, osize_reg[23:0]};
    assign psize_sum  = {1'b0, psize_reg} + 33'(HEADER_BYTES);
    assign last_byte  = (pleft_reg == 32'd1);
    assign mlen       = {1'b0, in_byte[3:0]} + 5'd3;
    assign mlen_w     = {27'd0, mlen};

    // Decode one accepted beat.
    always_comb begin
        phase_next  = phase_reg;
        hdr_next    = hdr_reg;
        psize_next  = psize_reg;
        osize_next  = osize_reg;
        remain_next = remain_reg;
        pleft_next  = pleft_reg;
        flag_next   = flag_reg;
        low_next    = low_reg;
        push        = 1'b0;
        push_cmd    = '0;
        if (in_beat) begin
            case (phase_reg)
                PH_HEADER: begin
                    hdr_next = hdr_reg + 4'd1;
                    if (hdr_reg[3:2] == 2'd0 && in_byte != MAGIC[hdr_reg[1:0]]) begin
                        push            = 1'b1;
                        push_cmd.kind   = CMD_ERR;
                        push_cmd.done   = 1'b1;
                        push_cmd.status = ST_BAD_MAGIC;
                        phase_next      = PH_DONE;
                    end else if (hdr_reg[3:2] == 2'd2) begin
                        psize_next[{hdr_reg[1:0], 3'b000} +: 8] = in_byte;
                    end else if (hdr_reg[3:2] == 2'd3) begin
                        osize_next[{hdr_reg[1:0], 3'b000} +: 8] = in_byte;
                    end
                    // The header completes: check the sizes.
                    if (hdr_reg == 4'd15) begin
                        push_cmd.kind = CMD_ERR;
                        push_cmd.done = 1'b1;
                        if (source_size < 32'(HEADER_BYTES) || osize_full == 32'd0 ||
                            osize_full > max_output_size ||
                            psize_sum > {1'b0, source_size}) begin
                            push            = 1'b1;
                            push_cmd.status = ST_BAD_SIZES;
                            phase_next      = PH_DONE;
                        end else if (psize_reg == 32'd0) begin
                            push            = 1'b1;
                            push_cmd.status = ST_EXHAUSTED;
                            phase_next      = PH_DONE;
                        end else begin
                            phase_next  = PH_PAYLOAD;
                            remain_next = osize_full;
                            pleft_next  = psize_reg;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    pleft_next = pleft_reg - 32'd1;
                    if (flag_reg < 9'd2) begin
                        flag_next = {1'b1, in_byte};
                        if (last_byte) begin
                            push            = 1'b1;
                            push_cmd.kind   = CMD_ERR;
                            push_cmd.done   = 1'b1;
                            push_cmd.status = ST_EXHAUSTED;
                            phase_next      = PH_DONE;
                        end
                    end else if (flag_reg[0]) begin
                        flag_next = flag_reg >> 1;
                        push      = 1'b1;
                        if (remain_reg > 32'd1 && last_byte) begin
                            push_cmd.kind   = CMD_ERR;
                            push_cmd.done   = 1'b1;
                            push_cmd.status = ST_EXHAUSTED;
                            phase_next      = PH_DONE;
                        end else begin
                            push_cmd.kind = CMD_LIT;
                            push_cmd.data = in_byte;
                            push_cmd.done = (remain_reg == 32'd1);
                            remain_next   = remain_reg - 32'd1;
                            if (remain_reg == 32'd1) begin
                                phase_next = PH_DONE;
                            end
                        end
                    end else begin
                        low_next   = in_byte;
                        phase_next = PH_MATCH2;
                        if (last_byte) begin
                            push            = 1'b1;
                            push_cmd.kind   = CMD_ERR;
                            push_cmd.done   = 1'b1;
                            push_cmd.status = ST_EXHAUSTED;
                            phase_next      = PH_DONE;
                        end
                    end
                end
                PH_MATCH2: begin
                    pleft_next = pleft_reg - 32'd1;
                    flag_next  = flag_reg >> 1;
                    phase_next = PH_PAYLOAD;
                    push       = 1'b1;
                    if (mlen_w > remain_reg) begin
                        push_cmd.kind   = CMD_ERR;
                        push_cmd.done   = 1'b1;
                        push_cmd.status = ST_OVERRUN;
                        phase_next      = PH_DONE;
                    end else if (mlen_w < remain_reg && last_byte) begin
                        push_cmd.kind   = CMD_ERR;
                        push_cmd.done   = 1'b1;
                        push_cmd.status = ST_EXHAUSTED;
                        phase_next      = PH_DONE;
                    end else begin
                        push_cmd.kind = CMD_MATCH;
                        push_cmd.pos  = {in_byte[7:4], low_reg};
                        push_cmd.len  = mlen;
                        push_cmd.done = (mlen_w == remain_reg);
                        remain_next   = remain_reg - mlen_w;
                        if (mlen_w == remain_reg) begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                default: begin
                    // Finished or failed: beats are dropped until reset.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            hdr_reg    <= 4'd0;
            psize_reg  <= 32'd0;
            osize_reg  <= 32'd0;
            remain_reg <= 32'd0;
            pleft_reg  <= 32'd0;
            flag_reg   <= 9'd0;
            low_reg    <= 8'd0;
        end else begin
            phase_reg  <= phase_next;
            hdr_reg    <= hdr_next;
            psize_reg  <= psize_next;
            osize_reg  <= osize_next;
            remain_reg <= remain_next;
            pleft_reg  <= pleft_next;
            flag_reg   <= flag_next;
            low_reg    <= low_next;
        end
    end

endmodule

FILE: rtl/lzss_back.sv
// ----------------------------------------------------------------------------
// lzss_back
// Executes commands against the 4 KiB history ring and drives the result
// register.
// ----------------------------------------------------------------------------
module lzss_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_empty,
    input  lzss_pkg::cmd_t       cmd,
    output logic                 pop,
    output logic                 busy,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_out_byte,
    output logic                 m_run_last,
    output logic                 m_stream_done,
    output logic [2:0]           m_status
);
    import lzss_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_MATCH = 2'd2;

    logic [7:0]         ring [WINDOW_SIZE];
    logic [7:0]         rdata_reg;
    logic               fwd_reg;
    logic [7:0]         fwd_data_reg;

    logic [1:0]         state_reg, state_next;
    logic [RING_AW-1:0] clr_reg, clr_next;
    logic [RING_AW-1:0] wpos_reg, wpos_next;
    logic [RING_AW-1:0] rpos_reg, rpos_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               mdone_reg, mdone_next;

    logic               ov_reg, ov_next;
    logic [7:0]         ob_reg, ob_next;
    logic               ol_reg, ol_next;
    logic               od_reg, od_next;
    logic [2:0]         os_reg, os_next;

    logic               we, re;
    logic [RING_AW-1:0] wa, ra;
    logic [7:0]         wd, copy_byte;
    logic               can_load;

    assign can_load  = !ov_reg || m_ready;
    assign copy_byte = fwd_reg ? fwd_data_reg : rdata_reg;

    // Command sequencing and ring port control.
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        wpos_next  = wpos_reg;
        rpos_next  = rpos_reg;
        cnt_next   = cnt_reg;
        mdone_next = mdone_reg;
        ov_next    = ov_reg && !m_ready;
        ob_next    = ob_reg;
        ol_next    = ol_reg;
        od_next    = od_reg;
        os_next    = os_reg;
        we  = 1'b0;
        wa  = wpos_reg;
        wd  = 8'd0;
        re  = 1'b0;
        ra  = rpos_reg;
        pop = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                we       = 1'b1;
                wa       = clr_reg;
                clr_next = clr_reg + RING_STEP;
                if (clr_reg == RING_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!cmd_empty) begin
                    case (cmd.kind)
                        CMD_MATCH: begin
                            pop        = 1'b1;
                            re         = 1'b1;
                            ra         = cmd.pos;
                            rpos_next  = cmd.pos + RING_STEP;
                            cnt_next   = cmd.len;
                            mdone_next = cmd.done;
                            state_next = S_MATCH;
                        end
                        CMD_LIT: begin
                            if (can_load) begin
                                pop       = 1'b1;
                                we        = 1'b1;
                                wd        = cmd.data;
                                wpos_next = wpos_reg + RING_STEP;
                                ov_next   = 1'b1;
                                ob_next   = cmd.data;
                                ol_next   = 1'b1;
                                od_next   = cmd.done;
                                os_next   = ST_OK;
                            end
                        end
                        default: begin
                            if (can_load) begin
                                pop     = 1'b1;
                                ov_next = 1'b1;
                                ob_next = 8'd0;
                                ol_next = 1'b0;
                                od_next = 1'b1;
                                os_next = cmd.status;
                            end
                        end
                    endcase
                end
            end
            S_MATCH: begin
                // One copied byte per cycle while the result register can load; the next read overlaps the write.
                if (can_load) begin
                    we        = 1'b1;
                    wd        = copy_byte;
                    wpos_next = wpos_reg + RING_STEP;
                    ov_next   = 1'b1;
                    ob_next   = copy_byte;
                    ol_next   = (cnt_reg == 5'd1);
                    od_next   = mdone_reg && (cnt_reg == 5'd1);
                    os_next   = ST_OK;
                    if (cnt_reg == 5'd1) begin
                        state_next = S_IDLE;
                    end else begin
                        re        = 1'b1;
                        rpos_next = rpos_reg + RING_STEP;
                        cnt_next  = cnt_reg - 5'd1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // History ring: one write and one registered read a cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            ring[wa] <= wd;
        end
        if (re) begin
            rdata_reg    <= ring[ra];
            fwd_reg      <= we && (wa == ra);
            fwd_data_reg <= wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            wpos_reg  <= RING_START;
            rpos_reg  <= '0;
            cnt_reg   <= 5'd0;
            mdone_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            wpos_reg  <= wpos_next;
            rpos_reg  <= rpos_next;
            cnt_reg   <= cnt_next;
            mdone_reg <= mdone_next;
            ov_reg    <= ov_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        ob_reg <= ob_next;
        ol_reg <= ol_next;
        od_reg <= od_next;
        os_reg <= os_next;
    end

    assign busy          = (state_reg == S_CLEAR);
    assign m_valid       = ov_reg;
    assign m_out_byte    = ob_reg;
    assign m_run_last    = ol_reg;
    assign m_stream_done = od_reg;
    assign m_status      = os_reg;

endmodule

FILE: rtl/lzss_checker.sv
// ----------------------------------------------------------------------------
// lzss_checker
// Port-level checks on the decompressor result channel.
// ----------------------------------------------------------------------------
`include "lzss_ring_decompressor_assert.svh"

module lzss_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_run_last,
    input logic       m_stream_done,
    input logic [2:0] m_status
);
    import lzss_pkg::*;

    // A stalled result beat stays offered.
    `LZSS_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped")
    // Error beats end the stream and carry a zero byte.
    `LZSS_ASSERT_SAME(a_err_done, aclk, aresetn, m_valid && m_status != ST_OK,
        m_stream_done && m_out_byte == 8'd0, "error beat malformed")
    // Error beats never mark the end of a run.
    `LZSS_ASSERT_SAME(a_err_last, aclk, aresetn, m_valid && m_status != ST_OK,
        !m_run_last, "error beat with run end")
    // Nothing follows the final beat.
    `LZSS_ASSERT_NEXT(a_after_done, aclk, aresetn, m_valid && m_ready && m_stream_done,
        !m_valid, "beat after stream end")

endmodule

bind lzss_ring_decompressor lzss_checker u_lzss_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_byte    (m_out_byte),
    .m_run_last    (m_run_last),
    .m_stream_done (m_stream_done),
    .m_status      (m_status)
);

FILE: verif/lzss_ring_decompressor_checker.sv
// ----------------------------------------------------------------------------
// lzss_ring_decompressor_checker
// Watches the byte channels and the register port of the LZSS decompressor,
// decodes every accepted container byte with its own copy of the ring and the
// header state, and compares each result beat with the oldest expected one.
// ----------------------------------------------------------------------------
module lzss_ring_decompressor_checker
    import lzss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_run_last,
    input  logic        m_stream_done,
    input  logic [2:0]  m_status,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_MATCH2,
        PH_DONE
    } decode_phase_e;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       stream_done;
        logic [2:0] status;
    } decoded_beat_t;

    decoded_beat_t expected_beats[$];

    // Shadow of the registers and of the decoder state.
    logic [31:0]        source_size_r;
    logic [31:0]        max_output_r;
    logic [7:0]         history [WINDOW_SIZE];
    logic [RING_AW-1:0] wr_pos;
    logic [8:0]         flag_bits;
    int unsigned        hdr_cnt;
    logic [31:0]        payload_len;
    logic [31:0]        out_len;
    logic [31:0]        n_out;
    logic [31:0]        n_in;
    logic [7:0]         low_byte;
    decode_phase_e      phase;

    assign pending = expected_beats.size();

    function automatic void push_beat(logic [7:0] data, logic done, logic [2:0] status);
        decoded_beat_t beat;
        beat.data        = data;
        beat.run_last    = 1'b0;
        beat.stream_done = done;
        beat.status      = status;
        expected_beats.push_back(beat);
    endfunction

    function automatic void abort_job(logic [2:0] status);
        phase = PH_DONE;
        push_beat(8'h00, 1'b1, status);
    endfunction

    function automatic void emit_decoded(logic [7:0] v);
        history[wr_pos] = v;
        wr_pos = wr_pos + RING_STEP;
        n_out = n_out + 1;
        if (n_out >= out_len) begin
            phase = PH_DONE;
            push_beat(v, 1'b1, ST_OK);
        end else begin
            push_beat(v, 1'b0, ST_OK);
        end
    endfunction

    function automatic void mark_run_last();
        expected_beats[expected_beats.size()-1].run_last = 1'b1;
    endfunction

    // Decodes one container byte and queues the beats that it yields.
    function automatic void decode_byte(logic [7:0] b);
        logic [RING_AW-1:0] src;
        logic [4:0]         len;
        logic [32:0]        room;
        case (phase)
            PH_HEADER: begin
                if (hdr_cnt < 4 && b != MAGIC[hdr_cnt]) begin
                    abort_job(ST_BAD_MAGIC);
                    return;
                end
                if (hdr_cnt >= 8 && hdr_cnt < 12)
                    payload_len = payload_len | (32'(b) << (8 * (hdr_cnt - 8)));
                else if (hdr_cnt >= 12 && hdr_cnt < 16)
                    out_len = out_len | (32'(b) << (8 * (hdr_cnt - 12)));
                hdr_cnt = hdr_cnt + 1;
                if (hdr_cnt == HEADER_BYTES) begin
                    if (source_size_r < HEADER_BYTES || out_len == 0 ||
                        out_len > max_output_r ||
                        {1'b0, payload_len} + 33'd16 > {1'b0, source_size_r})
                        abort_job(ST_BAD_SIZES);
                    else if (payload_len == 0)
                        abort_job(ST_EXHAUSTED);
                    else
                        phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_in = n_in + 1;
                if (flag_bits < 2) begin
                    // A fresh flag byte with a marker bit above it.
                    flag_bits = {1'b1, b};
                    if (n_in >= payload_len)
                        abort_job(ST_EXHAUSTED);
                end else if (flag_bits[0]) begin
                    flag_bits = flag_bits >> 1;
                    if ({1'b0, n_out} + 33'd1 < {1'b0, out_len} && n_in >= payload_len) begin
                        abort_job(ST_EXHAUSTED);
                    end else begin
                        emit_decoded(b);
                        mark_run_last();
                    end
                end else begin
                    low_byte = b;
                    phase = PH_MATCH2;
                    if (n_in >= payload_len)
                        abort_job(ST_EXHAUSTED);
                end
            end
            PH_MATCH2: begin
                src = {b[7:4], low_byte};
                len = 5'(b[3:0]) + 5'd3;
                n_in = n_in + 1;
                flag_bits = flag_bits >> 1;
                phase = PH_PAYLOAD;
                room = {1'b0, out_len} - {1'b0, n_out};
                if (33'(len) > room) begin
                    abort_job(ST_OVERRUN);
                end else if ({1'b0, n_out} + 33'(len) < {1'b0, out_len} &&
                             n_in >= payload_len) begin
                    abort_job(ST_EXHAUSTED);
                end else begin
                    // Copied one byte at a time, so an overlapping copy repeats.
                    for (int i = 0; i < len; i++) begin
                        emit_decoded(history[src]);
                        src = src + RING_STEP;
                    end
                    mark_run_last();
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // Prediction on accepted input beats, comparison on accepted result beats.
    always @(posedge aclk) begin
        decoded_beat_t want;
        if (!aresetn) begin
            source_size_r <= 32'd16;
            max_output_r  <= 32'hFFFF_FFFF;
            for (int i = 0; i < WINDOW_SIZE; i++)
                history[i] = 8'h00;
            wr_pos       = RING_START;
            flag_bits    = '0;
            hdr_cnt      = 0;
            payload_len  = '0;
            out_len      = '0;
            n_out        = '0;
            n_in         = '0;
            low_byte     = '0;
            phase        = PH_HEADER;
            fail_count   = 0;
            results_seen = 0;
            expected_beats.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_SOURCE_SIZE)
                    source_size_r <= cfg_wdata;
                else
                    max_output_r <= cfg_wdata;
            end
            if (s_valid && s_ready)
                decode_byte(s_in_byte);
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_beats.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat byte %02h status %0d",
                                              m_out_byte, m_status));
                end else begin
                    want = expected_beats.pop_front();
                    if (m_out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  m_out_byte, want.data));
                    if (m_run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %b, expected %b",
                                                  m_run_last, want.run_last));
                    if (m_stream_done !== want.stream_done)
                        report_mismatch($sformatf("stream_done %b, expected %b",
                                                  m_stream_done, want.stream_done));
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_status, want.status));
                end
            end
        end
    end

endmodule

FILE: verif/lzss_ring_decompressor_tb.sv
// ----------------------------------------------------------------------------
// lzss_ring_decompressor_tb
// Feeds one LZSS container through the decompressor: a directed opening of
// literals and overlapping matches, then random flag groups, with random
// gaps on both channels, a long receiver hold-off and a drain pause. The
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module lzss_ring_decompressor_tb;

    import lzss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 60;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_run_last;
    logic        m_stream_done;
    logic [2:0]  m_status;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int results_seen;

    logic [7:0]  payload_q[$];
    int unsigned produced;
    int unsigned beats_sent;

    always #2 aclk = ~aclk;

    lzss_ring_decompressor dut (.*);

    lzss_ring_decompressor_checker checker_i (.*);

    // Receiver: random stalls, one long hold-off, one calm stretch.
    initial begin
        int hold;
        bit held;
        hold = 0;
        held = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else if (!held && results_seen >= 40) begin
                held = 1;
                hold = 400;
                m_ready <= 1'b0;
            end else if (results_seen >= 120 && results_seen < 220) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 29);
            end
        end
    end

    // Sends one beat, idling at random beforehand outside the calm stretch.
    task automatic send_byte(logic [7:0] b);
        bit calm;
        calm = (beats_sent >= 60 && beats_sent < 120);
        while (!calm && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic add_match(logic [11:0] offs, logic [3:0] nib);
        payload_q.push_back(offs[7:0]);
        payload_q.push_back({offs[11:8], nib});
        produced += nib + 3;
    endtask

    task automatic add_literal(logic [7:0] b);
        payload_q.push_back(b);
        produced++;
    endtask

    // Timeout guard.
    initial begin
        #3_000_000;
        $display("lzss_ring_decompressor verification failed");
        $finish;
    end

    initial begin
        logic [7:0]  flag;
        logic [31:0] out_size;
        logic [31:0] container_size;
        logic [31:0] max_out;
        logic [31:0] hdr_word;
        logic [11:0] offs;

        produced   = 0;
        beats_sent = 0;

        // Directed opening: extreme literals, then short, long, wrapping and
        // overlapping matches against the fresh window.
        payload_q.push_back(8'hFF);
        add_literal(8'h00); add_literal(8'hFF); add_literal(8'h5A); add_literal(8'hA5);
        add_literal(8'h01); add_literal(8'h80); add_literal(8'h7F); add_literal(8'hFE);
        payload_q.push_back(8'h00);
        add_match(12'(RING_START + 7), 4'h0);
        add_match(12'(RING_START), 4'hF);
        add_match(12'hFFF, 4'h1);
        add_match(12'h000, 4'h2);
        add_match(12'(RING_START + 2), 4'hF);
        add_match(12'(RING_START + 60), 4'h0);
        add_match(12'($urandom), 4'($urandom));
        add_match(12'($urandom), 4'($urandom));

        // Random flag groups, about half of the matches reaching into recent history.
        while (payload_q.size() < 190) begin
            flag = 8'($urandom);
            payload_q.push_back(flag);
            for (int i = 0; i < 8; i++) begin
                if (flag[i]) begin
                    add_literal(8'($urandom));
                end else begin
                    if ($urandom_range(1))
                        offs = 12'(RING_START + produced - $urandom_range(1, 20));
                    else
                        offs = 12'($urandom);
                    add_match(offs, 4'($urandom));
                end
            end
        end

        // Exact finish, truncated payload or an early end with a likely overrun.
        case ($urandom_range(2))
            0: out_size = produced;
            1: out_size = produced + $urandom_range(1, 30);
            default: out_size = produced - $urandom_range(1, 30);
        endcase
        container_size = $urandom_range(1) ? 32'(payload_q.size() + HEADER_BYTES)
                                           : 32'hFFFF_FFFF;
        case ($urandom_range(2))
            0: max_out = out_size;
            1: max_out = 32'hFFFF_FFFF;
            default: max_out = out_size + $urandom_range(1, 1000);
        endcase

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extremes first, then the values this job needs.
        write_reg(REG_SOURCE_SIZE, 32'd0);
        write_reg(REG_MAX_OUTPUT, 32'd1);
        write_reg(REG_SOURCE_SIZE, container_size);
        write_reg(REG_MAX_OUTPUT, max_out);

        // Header: magic, four don't-care bytes, then both sizes little-endian.
        for (int i = 0; i < 4; i++)
            send_byte(MAGIC[i]);
        hdr_word = $urandom;
        for (int i = 0; i < 4; i++)
            send_byte(hdr_word[8*i +: 8]);
        hdr_word = payload_q.size();
        for (int i = 0; i < 4; i++)
            send_byte(hdr_word[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            send_byte(out_size[8*i +: 8]);

        foreach (payload_q[i]) begin
            if (i == 150)
                wait_drained();
            send_byte(payload_q[i]);
        end
        wait_drained();

        // The job is over: new register values and stray bytes change nothing.
        write_reg(REG_SOURCE_SIZE, 32'hFFFF_FFFF);
        write_reg(REG_MAX_OUTPUT, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++)
            send_byte(8'($urandom));
        wait_drained();

        if (fail_count == 0 && pending == 0)
            $display("lzss_ring_decompressor verification clean");
        else
            $display("lzss_ring_decompressor verification failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lzss_pkg.sv
rtl/lzss_cmd_fifo.sv
rtl/lzss_front.sv
rtl/lzss_back.sv
rtl/lzss_ring_decompressor.sv
rtl/lzss_checker.sv
verif/lzss_ring_decompressor_checker.sv
verif/lzss_ring_decompressor_tb.sv
